/* design/failed_attempt_lockout_table_top_defines.svh */
// ----------------------------------------------------------------------------
// Lockout table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FAILED_ATTEMPT_LOCKOUT_TABLE_TOP_DEFINES_SVH
`define FAILED_ATTEMPT_LOCKOUT_TABLE_TOP_DEFINES_SVH

// Property holds at every sampled edge.
`define FALT_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define FALT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FALT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/falt_pkg.sv */
// ----------------------------------------------------------------------------
// Lockout table package
// Types, register map, opcodes and sizing shared by the lockout table blocks.
// ----------------------------------------------------------------------------
package falt_pkg;

	localparam int ENTRIES = 16;
	localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ADDR_W  = 4;

	localparam logic [1:0] OP_CHECK   = 2'd0;
	localparam logic [1:0] OP_FAIL    = 2'd1;
	localparam logic [1:0] OP_SUCCESS = 2'd2;
	localparam logic [1:0] OP_RSVD    = 2'd3;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_MAXATT = 2'd1;
	localparam logic [1:0] REG_BLOCK  = 2'd2;

	localparam logic [15:0] WINDOW_RST = 16'd300;
	localparam logic [7:0]  MAXATT_RST = 8'd5;
	localparam logic [15:0] BLOCK_RST  = 16'd300;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] address_key;
		logic        address_absent;
		logic [31:0] now_seconds;
	} in_t;

	typedef struct packed {
		logic        allowed;
		logic [15:0] seconds_left;
		logic [7:0]  attempt_count;
		logic        now_blocked;
		logic        fresh_entry;
		logic [3:0]  entry_slot;
	} out_t;

	typedef struct packed {
		logic [15:0] window_secs;
		logic [7:0]  max_attempts;
		logic [15:0] block_secs;
	} cfg_t;

	// Record that walks the cell chain during a lookup
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] oldest;
		logic [31:0]       oldest_start;
		logic [7:0]        att;
		logic [31:0]       start;
		logic [31:0]       bend;
	} scan_t;

	// Entry write broadcast to all cells
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [63:0]       key;
		logic [7:0]        att;
		logic [31:0]       start;
		logic [31:0]       bend;
	} wr_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_EVAL   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

/* design/falt_cell.sv */
// ----------------------------------------------------------------------------
// Lockout table cell
// Holds one table entry and advances the lookup record by one position.
// ----------------------------------------------------------------------------
module falt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [falt_pkg::SLOT_W-1:0] idx,
	input  logic                       head,
	input  logic [63:0]                key,
	input  logic                       rec_in_valid,
	input  falt_pkg::scan_t            rec_in,
	output logic                       rec_out_valid,
	output falt_pkg::scan_t            rec_out,
	input  falt_pkg::wr_t              wr
);
	import falt_pkg::*;

	logic        valid_q;
	logic [63:0] key_q;
	logic [7:0]  att_q;
	logic [31:0] start_q;
	logic [31:0] bend_q;
	logic        rec_v_q;
	scan_t       rec_q;
	scan_t       rec_nxt;

	always_comb begin
		rec_nxt = rec_in;
		priority if (!rec_in.hit && valid_q && (key_q == key)) begin
			rec_nxt.hit   = 1'b1;
			rec_nxt.slot  = idx;
			rec_nxt.att   = att_q;
			rec_nxt.start = start_q;
			rec_nxt.bend  = bend_q;
		end else if (!rec_in.hit && (head || (start_q < rec_in.oldest_start))) begin
			// strict compare keeps the lowest index on a tie
			rec_nxt.oldest       = idx;
			rec_nxt.oldest_start = start_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			key_q   <= '0;
			att_q   <= '0;
			start_q <= '0;
			bend_q  <= '0;
		end else if (wr.en && (wr.slot == idx)) begin
			valid_q <= 1'b1;
			key_q   <= wr.key;
			att_q   <= wr.att;
			start_q <= wr.start;
			bend_q  <= wr.bend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_v_q <= 1'b0;
		end else begin
			rec_v_q <= rec_in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_in_valid) begin
			rec_q <= rec_nxt;
		end
	end

	assign rec_out_valid = rec_v_q;
	assign rec_out       = rec_q;

endmodule

/* design/falt_regs.sv */
// ----------------------------------------------------------------------------
// Lockout table registers
// APB register file for window length, attempt limit and block length.
// ----------------------------------------------------------------------------
module falt_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [falt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output falt_pkg::cfg_t             cfg
);
	import falt_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_secs  <= WINDOW_RST;
			cfg_q.max_attempts <= MAXATT_RST;
			cfg_q.block_secs   <= BLOCK_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WINDOW: cfg_q.window_secs  <= pwdata[15:0];
				REG_MAXATT: cfg_q.max_attempts <= pwdata[7:0];
				REG_BLOCK:  cfg_q.block_secs   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW: prdata = {16'd0, cfg_q.window_secs};
			REG_MAXATT: prdata = {24'd0, cfg_q.max_attempts};
			REG_BLOCK:  prdata = {16'd0, cfg_q.block_secs};
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* design/failed_attempt_lockout_table_top.sv */
// ----------------------------------------------------------------------------
// Failed attempt lockout table, top level
// Lookup walks ENTRIES cells one per cycle. A new beat is taken only once the
// previous beat has finished; absent and reserved beats skip the cell chain.
// An output stall holds the block for as long as it lasts.
// arst_n clears every entry and loads the register defaults at once.
// ----------------------------------------------------------------------------
`include "failed_attempt_lockout_table_top_defines.svh"

module failed_attempt_lockout_table_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  falt_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output falt_pkg::out_t             out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [falt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import falt_pkg::*;

	cfg_t              cfg;
	state_t            state_q;
	logic              in_acc;
	logic              bypass_in;
	logic              launch_q;

	logic [1:0]        op_q;
	logic [63:0]       key_q;
	logic [31:0]       now_q;
	logic              bypass_q;

	logic [SLOT_W-1:0] slot_q;
	logic              fresh_q;
	logic [7:0]        cur_att_q;
	logic [31:0]       cur_start_q;
	logic [31:0]       cur_bend_q;

	logic              expired_q;
	logic              blk_run_q;
	logic [15:0]       left_q;
	logic [31:0]       bend_sum_q;

	logic              expired;
	logic              blk_run;
	logic [31:0]       diff_left;
	logic [32:0]       sum_bend;

	logic              out_valid_q;
	out_t              out_q;
	logic              out_free;
	logic              finish_go;
	out_t              res;
	wr_t               wr;
	logic [7:0]        base_att;
	logic [31:0]       base_start;
	logic [31:0]       base_bend;

	logic [ENTRIES:0]  chain_v;
	scan_t             chain_rec [ENTRIES+1];
	logic [ENTRIES-1:0] tok_v;

	falt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign bypass_in = in_data.address_absent || (in_data.opcode == OP_RSVD);

	// Launch the lookup record in the cycle after acceptance, once key_q holds the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= 1'b0;
		end else begin
			launch_q <= in_acc && !bypass_in;
		end
	end

	assign chain_v[0]   = launch_q;
	assign chain_rec[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		falt_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.idx           (SLOT_W'(i)),
			.head          (i == 0),
			.key           (key_q),
			.rec_in_valid  (chain_v[i]),
			.rec_in        (chain_rec[i]),
			.rec_out_valid (chain_v[i+1]),
			.rec_out       (chain_rec[i+1]),
			.wr            (wr)
		);
	end

	assign tok_v = chain_v[ENTRIES:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= bypass_in ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain_v[ENTRIES]) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// key_q feeds the cell compares, so it must be in place when the record enters
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= in_data.opcode;
			now_q    <= in_data.now_seconds;
			bypass_q <= bypass_in;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= in_data.address_key;
		end
	end

	// Select the served entry at the chain tail; a miss takes over the oldest entry, cleared
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && chain_v[ENTRIES]) begin
			fresh_q <= !chain_rec[ENTRIES].hit;
			if (chain_rec[ENTRIES].hit) begin
				slot_q      <= chain_rec[ENTRIES].slot;
				cur_att_q   <= chain_rec[ENTRIES].att;
				cur_start_q <= chain_rec[ENTRIES].start;
				cur_bend_q  <= chain_rec[ENTRIES].bend;
			end else begin
				slot_q      <= chain_rec[ENTRIES].oldest;
				cur_att_q   <= '0;
				cur_start_q <= now_q;
				cur_bend_q  <= '0;
			end
		end
	end

	always_comb begin
		expired   = (now_q > cur_start_q) &&
			((now_q - cur_start_q) > {16'd0, cfg.window_secs});
		blk_run   = (cur_bend_q != '0) && (now_q < cur_bend_q);
		diff_left = cur_bend_q - now_q;
		sum_bend  = {1'b0, now_q} + {17'd0, cfg.block_secs};
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			expired_q  <= expired;
			blk_run_q  <= blk_run;
			left_q     <= (diff_left[31:16] != '0) ? 16'hFFFF : diff_left[15:0];
			bend_sum_q <= sum_bend[32] ? 32'hFFFF_FFFF : sum_bend[31:0];
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign finish_go = (state_q == ST_FINISH) && out_free;

	always_comb begin
		base_att   = expired_q ? 8'd0 : cur_att_q;
		base_start = expired_q ? now_q : cur_start_q;
		base_bend  = expired_q ? 32'd0 : cur_bend_q;

		res       = '0;
		wr.en     = finish_go && !bypass_q;
		wr.slot   = slot_q;
		wr.key    = key_q;
		wr.att    = cur_att_q;
		wr.start  = cur_start_q;
		wr.bend   = cur_bend_q;

		if (bypass_q) begin
			res.allowed = (op_q == OP_CHECK);
		end else begin
			unique case (op_q)
				OP_CHECK: begin
					if (blk_run_q) begin
						res.seconds_left = left_q;
					end else begin
						res.allowed = 1'b1;
						wr.att      = base_att;
						wr.start    = base_start;
						wr.bend     = base_bend;
					end
				end
				OP_FAIL: begin
					wr.att   = (base_att == 8'hFF) ? base_att : base_att + 8'd1;
					wr.start = base_start;
					wr.bend  = base_bend;
					if (wr.att >= cfg.max_attempts) begin
						wr.bend         = bend_sum_q;
						res.now_blocked = 1'b1;
					end
				end
				OP_SUCCESS: begin
					wr.att  = '0;
					wr.bend = '0;
				end
				OP_RSVD: ;
			endcase
			res.attempt_count = wr.att;
			res.fresh_entry   = fresh_q;
			res.entry_slot    = 4'(slot_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`FALT_ASSERT_ALWAYS(a_one_token, $onehot0(tok_v), "more than one lookup in the cell chain")
	`FALT_ASSERT_SAME(a_idle_chain, !in_stall, tok_v == '0, "beat taken while chain busy")
	`FALT_ASSERT_NEXT(a_write_out, wr.en, out_valid, "entry written without a result beat")

endmodule

/* sim/failed_attempt_lockout_table_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lockout table testbench
// Drives check, failure, success and reserved beats, some with the address absent,
// with random idling on both sides and compares every result with a behavioral copy
// of the lockout table, over several register settings that include the extremes of
// each register.
module failed_attempt_lockout_table_top_tb;
	import falt_pkg::*;

	localparam int LONG_HOLD  = 300;
	localparam int WATCHDOG   = 3000;
	localparam int SETTLE     = ENTRIES + 8;
	localparam int KEY_POOL_N = 24;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_t               in_data  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_t              out_data;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;

	failed_attempt_lockout_table_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// Shadow copy of the table and its registers
	logic        tbl_valid     [ENTRIES];
	logic [63:0] tbl_key       [ENTRIES];
	logic [7:0]  tbl_count     [ENTRIES];
	logic [31:0] tbl_start     [ENTRIES];
	logic [31:0] tbl_block_end [ENTRIES];
	logic [15:0] cfg_window;
	logic [7:0]  cfg_max_att;
	logic [15:0] cfg_block;

	in_t         pending_reqs[$];
	out_t        expected_verdicts[$];
	logic [63:0] key_pool[KEY_POOL_N];
	logic [31:0] clock_now;

	int unsigned src_gap_max     = 7;
	int unsigned sink_stall_max  = 7;
	int unsigned src_gap         = 0;
	int unsigned sink_wait       = 0;
	int unsigned long_left       = 0;
	int unsigned long_hold_asks  = 0;
	int unsigned long_hold_done  = 0;
	int unsigned quiet_cycles    = 0;
	int unsigned accepted_reqs   = 0;
	int unsigned counted_reqs    = 0;
	int unsigned refused_checks  = 0;
	int unsigned blocks_set      = 0;
	int unsigned reused_entries  = 0;
	int unsigned mismatches      = 0;

	function automatic void restart_window(input int unsigned slot, input logic [31:0] now);
		if (now > tbl_start[slot] && (now - tbl_start[slot]) > {16'h0, cfg_window}) begin
			tbl_count[slot]     = '0;
			tbl_start[slot]     = now;
			tbl_block_end[slot] = '0;
		end
	endfunction

	function automatic out_t judge_request(input in_t req);
		out_t        verdict;
		logic        hit;
		int unsigned slot;
		int unsigned oldest;
		logic [31:0] now;
		logic [31:0] remain;
		logic [32:0] end_sum;
		verdict = '0;
		now = req.now_seconds;
		if (req.opcode == OP_RSVD || req.address_absent) begin
			verdict.allowed = (req.opcode == OP_CHECK);
			return verdict;
		end
		hit = 1'b0;
		slot = 0;
		oldest = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!hit) begin
				if (tbl_valid[i] && tbl_key[i] == req.address_key) begin
					hit = 1'b1;
					slot = i;
				end else if (tbl_start[i] < tbl_start[oldest]) begin
					oldest = i;
				end
			end
		end
		// Miss: take over the entry whose window started first
		if (!hit) begin
			slot = oldest;
			tbl_valid[slot]     = 1'b1;
			tbl_key[slot]       = req.address_key;
			tbl_count[slot]     = '0;
			tbl_start[slot]     = now;
			tbl_block_end[slot] = '0;
			verdict.fresh_entry = 1'b1;
		end
		case (req.opcode)
			OP_CHECK: begin
				if (tbl_block_end[slot] != 0 && now < tbl_block_end[slot]) begin
					remain = tbl_block_end[slot] - now;
					verdict.seconds_left = (remain > 32'hFFFF) ? 16'hFFFF : remain[15:0];
				end else begin
					restart_window(slot, now);
					verdict.allowed = 1'b1;
				end
			end
			OP_FAIL: begin
				restart_window(slot, now);
				if (tbl_count[slot] != 8'hFF)
					tbl_count[slot] = tbl_count[slot] + 8'd1;
				if (tbl_count[slot] >= cfg_max_att) begin
					end_sum = {1'b0, now} + {17'h0, cfg_block};
					tbl_block_end[slot] = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
					verdict.now_blocked = 1'b1;
				end
			end
			default: begin
				tbl_count[slot]     = '0;
				tbl_block_end[slot] = '0;
			end
		endcase
		verdict.attempt_count = tbl_count[slot];
		verdict.entry_slot = 4'(slot);
		return verdict;
	endfunction

	function automatic void match_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_verdict(input out_t got);
		out_t want;
		if (expected_verdicts.size() == 0) begin
			$error("result beat with nothing outstanding: %h", got);
			mismatches++;
		end else begin
			want = expected_verdicts.pop_front();
			match_field("allowed", want.allowed, got.allowed);
			match_field("seconds_left", want.seconds_left, got.seconds_left);
			match_field("attempt_count", want.attempt_count, got.attempt_count);
			match_field("now_blocked", want.now_blocked, got.now_blocked);
			match_field("fresh_entry", want.fresh_entry, got.fresh_entry);
			match_field("entry_slot", want.entry_slot, got.entry_slot);
			if (want.seconds_left != 0)
				refused_checks++;
			if (want.now_blocked)
				blocks_set++;
			if (want.fresh_entry)
				reused_entries++;
		end
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_verdicts.push_back(judge_request(in_data));
				accepted_reqs++;
			end
			// Hold the beat while stalled, else idle out the gap or advance
			if (!in_valid || !in_stall) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					in_data <= pending_reqs.pop_front();
					in_valid <= 1'b1;
					src_gap <= $urandom_range(0, src_gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and stall generator
	always @(posedge clk or negedge arst_n) begin : sink_proc
		int unsigned wait_v;
		int unsigned hold_v;
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_wait <= 0;
			long_left <= 0;
		end else begin
			wait_v = sink_wait;
			hold_v = long_left;
			if (out_valid && !out_stall) begin
				check_verdict(out_data);
				wait_v = $urandom_range(0, sink_stall_max);
			end else if (out_valid && wait_v != 0 && hold_v == 0) begin
				wait_v--;
			end
			if (hold_v != 0) begin
				hold_v--;
			end else if (long_hold_done < long_hold_asks) begin
				hold_v = LONG_HOLD;
				long_hold_done++;
			end
			sink_wait <= wait_v;
			long_left <= hold_v;
			out_stall <= (wait_v != 0) || (hold_v != 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic void queue_req(input logic [1:0] op, input logic [63:0] key,
			input logic absent, input logic [31:0] now);
		in_t req;
		req.opcode = op;
		req.address_key = key;
		req.address_absent = absent;
		req.now_seconds = now;
		pending_reqs.push_back(req);
		if (op != OP_RSVD && !absent)
			counted_reqs++;
	endfunction

	function automatic logic [63:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [31:0] advance_time();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			clock_now += $urandom_range(0, 3);
		else if (r < 85)
			clock_now += $urandom_range(0, 2 * cfg_window + 2);
		else if (r < 93)
			clock_now += $urandom_range(0, 2 * cfg_block + 2);
		else if (r < 97)
			clock_now -= $urandom_range(1, 60);
		else
			clock_now = $urandom();
		return clock_now;
	endfunction

	function automatic void queue_episode();
		logic [63:0] key;
		int unsigned kind;
		int unsigned burst_cap;
		int unsigned n;
		key = pick_key();
		kind = $urandom_range(0, 99);
		burst_cap = (cfg_max_att > 12) ? 12 : cfg_max_att;
		if (kind < 55) begin
			// Attack: failures sprinkled with checks, then a final check
			n = $urandom_range(1, burst_cap + 3);
			for (int i = 0; i < n; i++)
				queue_req(($urandom_range(0, 3) == 0) ? OP_CHECK : OP_FAIL, key, 1'b0,
					advance_time());
			queue_req(OP_CHECK, key, 1'b0, advance_time());
		end else if (kind < 70) begin
			queue_req(OP_FAIL, key, 1'b0, advance_time());
			queue_req(OP_SUCCESS, key, 1'b0, advance_time());
			queue_req(OP_CHECK, key, 1'b0, advance_time());
		end else if (kind < 90) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				queue_req(2'($urandom_range(0, 2)), pick_key(), 1'b0, advance_time());
		end else if (kind < 95) begin
			queue_req(2'($urandom_range(0, 3)), {$urandom(), $urandom()}, 1'b1,
				advance_time());
		end else begin
			queue_req(OP_RSVD, {$urandom(), $urandom()}, 1'($urandom_range(0, 1)),
				advance_time());
		end
	endfunction

	function automatic void fill_phase(input int unsigned n);
		int unsigned goal;
		goal = counted_reqs + n;
		while (counted_reqs < goal)
			queue_episode();
	endfunction

	task automatic drain();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_verdicts.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// Read it back
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== value) begin
			$error("register %0d readback: expected %0h, got %0h", idx, value, prdata);
			mismatches++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic setup_phase(input logic [15:0] window, input logic [7:0] max_att,
			input logic [15:0] block, input int unsigned gap_max,
			input int unsigned stall_max, input bit long_hold);
		drain();
		write_reg(REG_WINDOW, {16'h0, window});
		write_reg(REG_MAXATT, {24'h0, max_att});
		write_reg(REG_BLOCK, {16'h0, block});
		cfg_window = window;
		cfg_max_att = max_att;
		cfg_block = block;
		src_gap_max = gap_max;
		sink_stall_max = stall_max;
		if (long_hold)
			long_hold_asks++;
		clock_now = $urandom();
	endtask

	initial begin
		logic [63:0] key_a;
		logic [63:0] key_b;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_count[i] = '0;
			tbl_start[i] = '0;
			tbl_block_end[i] = '0;
		end
		cfg_window = WINDOW_RST;
		cfg_max_att = MAXATT_RST;
		cfg_block = BLOCK_RST;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < KEY_POOL_N; i++)
			key_pool[i] = {$urandom(), $urandom()};
		key_a = key_pool[2];
		key_b = key_pool[3];

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset register values
		queue_req(OP_CHECK, key_a, 1'b0, 32'd0);
		queue_req(OP_CHECK, key_b, 1'b1, 32'd1);
		queue_req(OP_FAIL, key_b, 1'b1, 32'd2);
		queue_req(OP_SUCCESS, key_b, 1'b1, 32'd3);
		queue_req(OP_RSVD, key_a, 1'b0, 32'd4);
		repeat (5) queue_req(OP_FAIL, key_a, 1'b0, 32'd10);
		queue_req(OP_CHECK, key_a, 1'b0, 32'd20);
		queue_req(OP_FAIL, key_a, 1'b0, 32'd21);
		queue_req(OP_SUCCESS, key_a, 1'b0, 32'd22);
		queue_req(OP_CHECK, key_a, 1'b0, 32'd23);
		queue_req(OP_CHECK, 64'h0, 1'b0, 32'd24);
		queue_req(OP_CHECK, '1, 1'b0, 32'd5);
		queue_req(OP_FAIL, key_a, 1'b0, 32'd400);
		queue_req(OP_CHECK, key_b, 1'b0, 32'hFFFF_FFFF);
		queue_req(OP_RSVD, '1, 1'b1, 32'hFFFF_FFFF);

		setup_phase(16'd1, 8'd1, 16'd1, 7, 7, 1'b0);
		fill_phase(210);

		// Largest settings: saturate the count and the block end near the top of time
		setup_phase(16'hFFFF, 8'hFF, 16'hFFFF, 7, 7, 1'b1);
		repeat (258) queue_req(OP_FAIL, key_pool[0], 1'b0, 32'hFFFF_FF00);
		queue_req(OP_CHECK, key_pool[0], 1'b0, 32'hFFFF_FF00 - 32'd70000);
		queue_req(OP_FAIL, key_pool[0], 1'b0, 32'hFFFF_FFFF);
		queue_req(OP_CHECK, key_pool[0], 1'b0, 32'hFFFF_FFFF);
		fill_phase(210);

		// Zero registers: every failure blocks, and a block end of zero stays unblocked
		setup_phase(16'd0, 8'd0, 16'd0, 3, 3, 1'b0);
		clock_now = '0;
		queue_req(OP_FAIL, key_b, 1'b0, 32'd0);
		queue_req(OP_CHECK, key_b, 1'b0, 32'd0);
		fill_phase(210);

		setup_phase(WINDOW_RST, MAXATT_RST, BLOCK_RST, 0, 0, 1'b0);
		fill_phase(210);

		setup_phase(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 12)),
			16'($urandom_range(1, 65535)), 7, 7, 1'b1);
		fill_phase(210);

		setup_phase(16'd20, 8'd3, 16'd40, 7, 7, 1'b0);
		fill_phase(210);

		setup_phase(16'($urandom_range(1, 600)), 8'($urandom_range(1, 8)),
			16'($urandom_range(1, 600)), 2, 7, 1'b0);
		fill_phase(210);

		drain();
		$display("ran %0d requests over eight register settings, absent and reserved ones too",
			accepted_reqs);
		$display("%0d refused checks, %0d blocks set, %0d entries reused",
			refused_checks, blocks_set, reused_entries);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/falt_pkg.sv
design/falt_cell.sv
design/falt_regs.sv
design/failed_attempt_lockout_table_top.sv
sim/failed_attempt_lockout_table_top_tb.sv
